>>> sv/sh9_pkg.sv
// shared types, constants and table functions for the sh9 irradiance projector
package sh9_pkg;

   localparam int NUM_TERMS   = 9;
   localparam int TERM_W      = 20;
   localparam int GAMMA_W     = 16;
   localparam int COLOR_W     = 16;
   localparam int DIR_W       = 16;
   localparam int CH_NUM      = 3;
   localparam int CH_W        = 2;
   localparam int IDX_W       = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int DIVISOR_W   = 18;
   localparam int QUOT_W      = 32;
   localparam int SCALE_W     = 6;
   localparam int COEFF_W     = 32;
   localparam int ROOT_W      = 256;

   typedef struct packed {
      logic [NUM_TERMS-1:0][TERM_W-1:0] term;
      logic [CH_NUM-1:0][GAMMA_W-1:0]   gamma;
      logic                             last;
   } sample_type;

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_RED,
      FR_GREEN,
      FR_BLUE,
      FR_TERM,
      FR_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_ACC,
      BK_LOAD,
      BK_CHECK,
      BK_DIV,
      BK_OUT
   } back_state_type;

   // band factor a * f^2 * 4 in sixteenths
   function automatic logic [SCALE_W-1:0] scale_k(input logic [IDX_W-1:0] idx);
      logic [SCALE_W-1:0] k;
      case (idx)
         4'd0:    k = 6'd16;
         4'd1:    k = 6'd32;
         4'd2:    k = 6'd32;
         4'd3:    k = 6'd32;
         4'd4:    k = 6'd60;
         4'd5:    k = 6'd60;
         4'd6:    k = 6'd5;
         4'd7:    k = 6'd60;
         4'd8:    k = 6'd15;
         default: k = 6'd0;
      endcase
      return k;
   endfunction

   // largest y with y^11 * depth^5 <= idx^5 * 2^176, i.e. floor(65536 * (idx/depth)^(5/11))
   function automatic logic [GAMMA_W-1:0] gamma_entry(input int unsigned idx,
                                                     input int unsigned depth);
      logic [ROOT_W-1:0] rhs;
      logic [ROOT_W-1:0] lhs;
      int unsigned       lo;
      int unsigned       hi;
      int unsigned       mid;
      int                i;
      int                s;
      rhs = ROOT_W'(1);
      for (i = 0; i < 5; i++) rhs = rhs * ROOT_W'(idx);
      rhs = rhs << 176;
      lo = 0;
      hi = 65535;
      for (s = 0; s < 17; s++) begin
         if (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            lhs = ROOT_W'(1);
            for (i = 0; i < 11; i++) lhs = lhs * ROOT_W'(mid);
            for (i = 0; i < 5; i++) lhs = lhs * ROOT_W'(depth);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
         end
      end
      return GAMMA_W'(lo);
   endfunction

endpackage

>>> sv/sh9_irradiance_projector_unit.sv
// top level of the order-2 spherical-harmonic irradiance projector
// Projects a stream of colour samples onto nine SH basis terms per RGB channel.
// The front part takes one sample at a time (three gamma table reads on one
// registered port, one multiply stage, one term stage) and hands it to a two-entry
// queue, waiting while the queue is full. The back part owns one multiply-accumulate
// unit; it picks up the queued item, then runs a multiply step and an accumulate
// step on each of the 3*NUM_COEFFS accumulators. On a sample marked last
// the back part emits the burst:
// each coefficient takes a load/scale step, a range check and the bit-serial
// divider by 4*sample_count (skipped and saturated when the quotient would overflow),
// then waits on the result port until taken. sample_count of zero divides as one;
// write it only while idle.
module sh9_irradiance_projector_unit #(
   parameter int NUM_COEFFS        = 9,
   parameter int ACC_WIDTH         = 48,
   parameter int GAMMA_TABLE_DEPTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [sh9_pkg::DIR_W-1:0]     req_dir_x,
   input  logic signed [sh9_pkg::DIR_W-1:0]     req_dir_y,
   input  logic signed [sh9_pkg::DIR_W-1:0]     req_dir_z,
   input  logic [sh9_pkg::COLOR_W-1:0]          req_red_in,
   input  logic [sh9_pkg::COLOR_W-1:0]          req_green_in,
   input  logic [sh9_pkg::COLOR_W-1:0]          req_blue_in,
   input  logic                                 req_last_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sh9_pkg::CH_W-1:0]             rsp_channel,
   output logic [sh9_pkg::IDX_W-1:0]            rsp_coeff_index,
   output logic signed [sh9_pkg::COEFF_W-1:0]   rsp_coefficient,
   output logic                                 rsp_last_coeff,
   input  logic                                 csr_wr_en,
   input  logic [15:0]                          csr_wr_data
);

   logic [15:0]                     sample_count_ff;
   logic [sh9_pkg::DIVISOR_W-1:0]   divisor;
   logic                            push;
   logic                            full;
   logic                            pop;
   logic                            nonempty;
   sh9_pkg::sample_type             push_data;
   sh9_pkg::sample_type             head;

   always_ff @(posedge clock) begin
      if (reset) sample_count_ff <= 16'd1024;
      else if (csr_wr_en) sample_count_ff <= csr_wr_data;
   end

   assign divisor = {(sample_count_ff == 16'd0) ? 16'd1 : sample_count_ff, 2'b00};

   sh9_front #(
      .GAMMA_TABLE_DEPTH(GAMMA_TABLE_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_dir_x       (req_dir_x),
      .req_dir_y       (req_dir_y),
      .req_dir_z       (req_dir_z),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .req_last_sample (req_last_sample),
      .push            (push),
      .push_data       (push_data),
      .full            (full)
   );

   sh9_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .nonempty  (nonempty),
      .head      (head)
   );

   sh9_back #(
      .NUM_COEFFS(NUM_COEFFS),
      .ACC_WIDTH (ACC_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .nonempty        (nonempty),
      .head            (head),
      .pop             (pop),
      .divisor         (divisor),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_channel     (rsp_channel),
      .rsp_coeff_index (rsp_coeff_index),
      .rsp_coefficient (rsp_coefficient),
      .rsp_last_coeff  (rsp_last_coeff)
   );

endmodule

>>> sv/sh9_queue.sv
// two-entry sample queue between the front and back parts
module sh9_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sh9_pkg::sample_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                nonempty,
   output sh9_pkg::sample_type head
);

   localparam int PTR_W = $clog2(sh9_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(sh9_pkg::QUEUE_DEPTH + 1);

   sh9_pkg::sample_type entry_ff [sh9_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = count_ff == CNT_W'(sh9_pkg::QUEUE_DEPTH);
   assign nonempty = count_ff != '0;
   assign head     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

>>> sv/sh9_front.sv
// front part: takes a sample, looks up gamma and forms the nine basis terms
module sh9_front #(
   parameter int GAMMA_TABLE_DEPTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [sh9_pkg::DIR_W-1:0]     req_dir_x,
   input  logic signed [sh9_pkg::DIR_W-1:0]     req_dir_y,
   input  logic signed [sh9_pkg::DIR_W-1:0]     req_dir_z,
   input  logic [sh9_pkg::COLOR_W-1:0]          req_red_in,
   input  logic [sh9_pkg::COLOR_W-1:0]          req_green_in,
   input  logic [sh9_pkg::COLOR_W-1:0]          req_blue_in,
   input  logic                                 req_last_sample,
   output logic                                 push,
   output sh9_pkg::sample_type                  push_data,
   input  logic                                 full
);

   localparam int GIDX_W = $clog2(GAMMA_TABLE_DEPTH);
   localparam int PROD_W = 2 * sh9_pkg::DIR_W;
   localparam int TW     = sh9_pkg::TERM_W;

   logic [sh9_pkg::GAMMA_W-1:0] gamma_rom [GAMMA_TABLE_DEPTH];

   for (genvar gi = 0; gi < GAMMA_TABLE_DEPTH; gi++) begin : g_rom
      localparam logic [sh9_pkg::GAMMA_W-1:0] ENTRY =
         sh9_pkg::gamma_entry(gi, GAMMA_TABLE_DEPTH);
      assign gamma_rom[gi] = ENTRY;
   end

   sh9_pkg::front_state_type state_ff, state_in;

   logic signed [sh9_pkg::DIR_W-1:0] x_ff, y_ff, z_ff;
   logic [sh9_pkg::CH_NUM-1:0][sh9_pkg::COLOR_W-1:0] color_ff;
   logic last_ff;
   logic [sh9_pkg::CH_NUM-1:0][sh9_pkg::GAMMA_W-1:0] gamma_ff;
   logic signed [PROD_W-1:0] xy_ff, yz_ff, zz_ff, xz_ff, xx_ff, yy_ff;
   logic [sh9_pkg::NUM_TERMS-1:0][TW-1:0] term_ff, term_in;

   logic                         accept;
   logic                         gamma_load;
   logic [sh9_pkg::CH_W-1:0]     gamma_sel;
   logic [GIDX_W-1:0]            rd_idx;
   logic signed [PROD_W:0]       sq_diff;
   logic signed [PROD_W+1:0]     zz3;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sh9_pkg::FR_IDLE:  if (req_valid) state_in = sh9_pkg::FR_RED;
         sh9_pkg::FR_RED:   state_in = sh9_pkg::FR_GREEN;
         sh9_pkg::FR_GREEN: state_in = sh9_pkg::FR_BLUE;
         sh9_pkg::FR_BLUE:  state_in = sh9_pkg::FR_TERM;
         sh9_pkg::FR_TERM:  state_in = sh9_pkg::FR_PUSH;
         sh9_pkg::FR_PUSH:  if (!full) state_in = sh9_pkg::FR_IDLE;
         default:           state_in = sh9_pkg::FR_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall  = state_ff != sh9_pkg::FR_IDLE;
      accept     = state_ff == sh9_pkg::FR_IDLE && req_valid;
      push       = state_ff == sh9_pkg::FR_PUSH && !full;
      gamma_load = 1'b0;
      gamma_sel  = '0;
      case (state_ff)
         sh9_pkg::FR_RED: begin
            gamma_load = 1'b1;
            gamma_sel  = 2'd0;
         end
         sh9_pkg::FR_GREEN: begin
            gamma_load = 1'b1;
            gamma_sel  = 2'd1;
         end
         sh9_pkg::FR_BLUE: begin
            gamma_load = 1'b1;
            gamma_sel  = 2'd2;
         end
         default: begin
            gamma_load = 1'b0;
            gamma_sel  = '0;
         end
      endcase
   end

   // table index is the top bits of the colour
   assign rd_idx = color_ff[gamma_sel][sh9_pkg::COLOR_W-1 -: GIDX_W];

   always_comb begin
      sq_diff    = (PROD_W+1)'(xx_ff) - (PROD_W+1)'(yy_ff);
      zz3        = ((PROD_W+2)'(zz_ff) <<< 1) + (PROD_W+2)'(zz_ff);
      term_in[0] = TW'(16384);
      term_in[1] = TW'(y_ff);
      term_in[2] = TW'(z_ff);
      term_in[3] = TW'(x_ff);
      term_in[4] = TW'(xy_ff >>> 14);
      term_in[5] = TW'(yz_ff >>> 14);
      term_in[6] = TW'(zz3 >>> 14) - TW'(16384);
      term_in[7] = TW'(xz_ff >>> 14);
      term_in[8] = TW'(sq_diff >>> 14);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= sh9_pkg::FR_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff        <= req_dir_x;
         y_ff        <= req_dir_y;
         z_ff        <= req_dir_z;
         color_ff[0] <= req_red_in;
         color_ff[1] <= req_green_in;
         color_ff[2] <= req_blue_in;
         last_ff     <= req_last_sample;
      end
      if (gamma_load) gamma_ff[gamma_sel] <= gamma_rom[rd_idx];
      if (state_ff == sh9_pkg::FR_RED) begin
         xy_ff <= x_ff * y_ff;
         yz_ff <= y_ff * z_ff;
         zz_ff <= z_ff * z_ff;
         xz_ff <= x_ff * z_ff;
         xx_ff <= x_ff * x_ff;
         yy_ff <= y_ff * y_ff;
      end
      if (state_ff == sh9_pkg::FR_TERM) term_ff <= term_in;
   end

   always_comb begin
      push_data.term  = term_ff;
      push_data.gamma = gamma_ff;
      push_data.last  = last_ff;
   end

endmodule

>>> sv/sh9_back.sv
// back part: accumulates samples and scales and emits the coefficient burst
module sh9_back #(
   parameter int NUM_COEFFS = 9,
   parameter int ACC_WIDTH  = 48
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  nonempty,
   input  sh9_pkg::sample_type                   head,
   output logic                                  pop,
   input  logic [sh9_pkg::DIVISOR_W-1:0]         divisor,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sh9_pkg::CH_W-1:0]              rsp_channel,
   output logic [sh9_pkg::IDX_W-1:0]             rsp_coeff_index,
   output logic signed [sh9_pkg::COEFF_W-1:0]    rsp_coefficient,
   output logic                                  rsp_last_coeff
);

   localparam int NUM_ACC = 3 * NUM_COEFFS;
   localparam int POS_W   = $clog2(NUM_ACC);
   localparam int PROD_W  = sh9_pkg::TERM_W + sh9_pkg::GAMMA_W + 1;
   localparam int SUM_W   = ACC_WIDTH + 1;
   localparam int PK_W    = ACC_WIDTH + sh9_pkg::SCALE_W;
   localparam int LIM_W   = sh9_pkg::DIVISOR_W + sh9_pkg::QUOT_W;
   localparam int CMP_W   = (PK_W > LIM_W) ? PK_W : LIM_W;
   localparam int QW      = sh9_pkg::QUOT_W;
   localparam int CNT_W   = $clog2(QW);
   localparam int REM_W   = sh9_pkg::DIVISOR_W + 1;

   sh9_pkg::back_state_type state_ff, state_in;

   logic [POS_W-1:0]               pos_ff;
   logic [sh9_pkg::CH_W-1:0]       ch_ff;
   logic [sh9_pkg::IDX_W-1:0]      idx_ff;
   logic signed [ACC_WIDTH-1:0]    acc_ff [NUM_ACC];
   logic signed [PROD_W-1:0]       prod_ff;
   logic [PK_W-1:0]                pk_ff;
   logic                           neg_ff;
   logic                           sat_ff;
   logic [REM_W-1:0]               rem_ff;
   logic [QW-1:0]                  quot_ff;
   logic [CNT_W-1:0]               cnt_ff;

   logic                               pos_last;
   logic                               idx_last;
   logic                               cnt_last;
   logic                               out_fire;
   logic                               over_limit;
   logic signed [sh9_pkg::TERM_W-1:0]  term_sel;
   logic signed [sh9_pkg::GAMMA_W:0]   gamma_sel;
   logic signed [ACC_WIDTH-1:0]        acc_rd;
   logic signed [SUM_W-1:0]            sum;
   logic signed [ACC_WIDTH-1:0]        acc_sat;
   logic [ACC_WIDTH-1:0]               mag;
   logic [REM_W-1:0]                   shifted;
   logic                               ge;

   assign pos_last = pos_ff == POS_W'(NUM_ACC - 1);
   assign idx_last = idx_ff == sh9_pkg::IDX_W'(NUM_COEFFS - 1);
   assign cnt_last = cnt_ff == CNT_W'(QW - 1);
   assign acc_rd   = acc_ff[pos_ff];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sh9_pkg::BK_IDLE:  if (nonempty) state_in = sh9_pkg::BK_MUL;
         sh9_pkg::BK_MUL:   state_in = sh9_pkg::BK_ACC;
         sh9_pkg::BK_ACC: begin
            if (!pos_last) state_in = sh9_pkg::BK_MUL;
            else if (head.last) state_in = sh9_pkg::BK_LOAD;
            else state_in = sh9_pkg::BK_IDLE;
         end
         sh9_pkg::BK_LOAD:  state_in = sh9_pkg::BK_CHECK;
         sh9_pkg::BK_CHECK: state_in = over_limit ? sh9_pkg::BK_OUT : sh9_pkg::BK_DIV;
         sh9_pkg::BK_DIV:   if (cnt_last) state_in = sh9_pkg::BK_OUT;
         sh9_pkg::BK_OUT: begin
            if (!rsp_stall) state_in = pos_last ? sh9_pkg::BK_IDLE : sh9_pkg::BK_LOAD;
         end
         default:           state_in = sh9_pkg::BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop             = state_ff == sh9_pkg::BK_ACC && pos_last;
      rsp_valid       = state_ff == sh9_pkg::BK_OUT;
      out_fire        = rsp_valid && !rsp_stall;
      rsp_channel     = ch_ff;
      rsp_coeff_index = idx_ff;
      rsp_last_coeff  = pos_last;
      if (sat_ff) rsp_coefficient = neg_ff ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      else if (neg_ff) rsp_coefficient = quot_ff[QW-1] ? {1'b1, {(QW-1){1'b0}}} : -quot_ff;
      else rsp_coefficient = quot_ff[QW-1] ? {1'b0, {(QW-1){1'b1}}} : quot_ff;
   end

   // datapath pieces
   always_comb begin
      term_sel   = head.term[idx_ff];
      gamma_sel  = {1'b0, head.gamma[ch_ff]};
      sum        = SUM_W'(acc_rd) + SUM_W'(prod_ff >>> 8);
      if (sum[SUM_W-1] != sum[SUM_W-2])
         acc_sat = sum[SUM_W-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                : {1'b0, {(ACC_WIDTH-1){1'b1}}};
      else acc_sat = sum[ACC_WIDTH-1:0];
      mag        = acc_rd[ACC_WIDTH-1] ? -acc_rd : acc_rd;
      // quotient would not fit in 32 bits
      over_limit = CMP_W'(pk_ff) >= CMP_W'({divisor, {QW{1'b0}}});
      shifted    = {rem_ff[REM_W-2:0], quot_ff[QW-1]};
      ge         = shifted >= REM_W'(divisor);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sh9_pkg::BK_IDLE;
         pos_ff   <= '0;
         ch_ff    <= '0;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         for (int i = 0; i < NUM_ACC; i++) acc_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == sh9_pkg::BK_ACC) || out_fire) begin
            if (state_ff == sh9_pkg::BK_ACC) acc_ff[pos_ff] <= acc_sat;
            else acc_ff[pos_ff] <= '0;
            if (pos_last) begin
               pos_ff <= '0;
               ch_ff  <= '0;
               idx_ff <= '0;
            end else begin
               pos_ff <= pos_ff + 1'b1;
               if (idx_last) begin
                  idx_ff <= '0;
                  ch_ff  <= ch_ff + 1'b1;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
         end
         if (state_ff == sh9_pkg::BK_CHECK) cnt_ff <= '0;
         else if (state_ff == sh9_pkg::BK_DIV) cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == sh9_pkg::BK_MUL) prod_ff <= term_sel * gamma_sel;
      if (state_ff == sh9_pkg::BK_LOAD) begin
         pk_ff  <= PK_W'(mag) * PK_W'(sh9_pkg::scale_k(idx_ff));
         neg_ff <= acc_rd[ACC_WIDTH-1];
      end
      if (state_ff == sh9_pkg::BK_CHECK) begin
         sat_ff  <= over_limit;
         rem_ff  <= REM_W'(pk_ff >> QW);
         quot_ff <= pk_ff[QW-1:0];
      end
      if (state_ff == sh9_pkg::BK_DIV) begin
         rem_ff  <= ge ? shifted - REM_W'(divisor) : shifted;
         quot_ff <= {quot_ff[QW-2:0], ge};
      end
   end

`ifndef SYNTHESIS
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> nonempty)
      else $error("queue popped while empty");

   a_burst_ends_idle: assert property (@(posedge clock) disable iff (reset)
      (out_fire && rsp_last_coeff) |=> state_ff == sh9_pkg::BK_IDLE)
      else $error("burst did not end after final coefficient");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      state_ff == sh9_pkg::BK_DIV |-> rem_ff < REM_W'(divisor))
      else $error("divider remainder out of range");

   a_cleared_after_emit: assert property (@(posedge clock) disable iff (reset)
      out_fire |=> acc_ff[$past(pos_ff)] == '0)
      else $error("accumulator not cleared after emit");
`endif

endmodule

>>> bench/sh9_irradiance_projector_unit_tb.sv
// testbench for the sh9 irradiance projector: directed table, random sample runs, burst checks
module sh9_irradiance_projector_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_OFF       = 3000;
   localparam int SETTLE         = 150;
   localparam longint ACC_MAX    = (64'sd1 <<< 47) - 1;
   localparam longint ACC_MIN    = -ACC_MAX - 1;
   localparam int BAND_K [9]     = '{16, 32, 32, 32, 60, 60, 5, 60, 15};

   typedef struct {
      logic [sh9_pkg::CH_W-1:0]           channel;
      logic [sh9_pkg::IDX_W-1:0]          index;
      logic signed [sh9_pkg::COEFF_W-1:0] coeff;
      logic                               last;
   } coeff_type;

   typedef struct {
      logic signed [15:0] x, y, z;
      logic [15:0]        r, g, b;
      logic               last;
      logic               zero_burst;   // every coefficient known to be zero
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_last_sample = 0;
   logic signed [15:0] req_dir_x = 0, req_dir_y = 0, req_dir_z = 0;
   logic [15:0] req_red_in = 0, req_green_in = 0, req_blue_in = 0;
   logic req_stall, rsp_valid, rsp_last_coeff;
   logic rsp_stall = 0;
   logic [sh9_pkg::CH_W-1:0] rsp_channel;
   logic [sh9_pkg::IDX_W-1:0] rsp_coeff_index;
   logic signed [sh9_pkg::COEFF_W-1:0] rsp_coefficient;
   logic csr_wr_en = 0;
   logic [15:0] csr_wr_data = 0;

   logic [15:0] gamma_lut [1024];
   longint      coeff_sum [27];
   logic [15:0] div_count;
   coeff_type   pending_coeffs [$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   bit          quiet = 0;
   bit          hold_request = 0;

   always #1 clock = ~clock;

   sh9_irradiance_projector_unit i_dut (.*);

   // gamma entry: largest v with v^11 <= idx^5 * 2^126 (depth 1024 = 2^10)
   function automatic void build_gamma();
      logic [255:0] limit, power;
      int lo, hi, mid;
      for (int idx = 0; idx < 1024; idx++) begin
         limit = 256'(idx);
         limit = (limit * limit * limit * limit * limit) << 126;
         lo = 0;
         hi = 65535;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            power = 256'(mid);
            for (int i = 1; i < 11; i++) power = power * 256'(mid);
            if (power <= limit) lo = mid;
            else hi = mid - 1;
         end
         gamma_lut[idx] = 16'(lo);
      end
   endfunction

   function automatic logic signed [31:0] scale_sum(longint acc, int k);
      longint unsigned n, d, m, q, r, mag;
      bit neg;
      n = (div_count == 0) ? 1 : div_count;
      d = 4 * n;
      neg = acc < 0;
      m = neg ? longint'(-(acc + 1)) + 1 : acc;
      q = m / d;
      r = m % d;
      if (q > (64'd1 << 32)) mag = 64'd1 << 32;
      else mag = q * k + (r * k) / d;
      if (neg) return (mag >= (64'd1 << 31)) ? 32'sh80000000 : -32'(mag);
      return (mag > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(mag);
   endfunction

   // accumulate one sample; on last, queue the 27 coefficients and clear
   function automatic void predict_sample(row_type s);
      longint x, y, z, t, gv;
      longint term [9];
      logic [15:0] colour [3];
      coeff_type c;
      x = s.x; y = s.y; z = s.z;
      colour = '{s.r, s.g, s.b};
      term = '{16384, y, z, x, (x * y) >>> 14, (y * z) >>> 14,
               ((3 * z * z) >>> 14) - 16384, (x * z) >>> 14, (x * x - y * y) >>> 14};
      for (int ch = 0; ch < 3; ch++) begin
         gv = gamma_lut[colour[ch] >> 6];
         for (int i = 0; i < 9; i++) begin
            t = (term[i] * gv) >>> 8;
            if (t > 0 && coeff_sum[ch*9+i] > ACC_MAX - t) coeff_sum[ch*9+i] = ACC_MAX;
            else if (t < 0 && coeff_sum[ch*9+i] < ACC_MIN - t) coeff_sum[ch*9+i] = ACC_MIN;
            else coeff_sum[ch*9+i] += t;
         end
      end
      if (!s.last) return;
      for (int ch = 0; ch < 3; ch++) begin
         for (int i = 0; i < 9; i++) begin
            c.channel = sh9_pkg::CH_W'(ch);
            c.index   = sh9_pkg::IDX_W'(i);
            c.coeff   = s.zero_burst ? 32'sd0 : scale_sum(coeff_sum[ch*9+i], BAND_K[i]);
            c.last    = (ch == 2 && i == 8);
            pending_coeffs.push_back(c);
            coeff_sum[ch*9+i] = 0;
         end
      end
   endfunction

   task automatic send_sample(row_type s);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid = 1;
      req_dir_x = s.x; req_dir_y = s.y; req_dir_z = s.z;
      req_red_in = s.r; req_green_in = s.g; req_blue_in = s.b;
      req_last_sample = s.last;
      do @(posedge clock); while (req_stall);
      predict_sample(s);
      @(negedge clock);
   endtask

   task automatic drain_and_settle();
      req_valid = 0;
      while (pending_coeffs.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_count(logic [15:0] value);
      csr_wr_en = 1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 0;
      div_count = value;
   endtask

   function automatic row_type random_sample(bit last);
      row_type s;
      real vx, vy, vz, norm;
      s.zero_burst = 0;
      s.last = last;
      if ($urandom_range(0, 9) < 7) begin
         vx = real'($urandom_range(0, 2000)) - 1000.0;
         vy = real'($urandom_range(0, 2000)) - 1000.0;
         vz = real'($urandom_range(0, 2000)) - 1000.0;
         norm = $sqrt(vx * vx + vy * vy + vz * vz);
         if (norm < 1.0) begin vz = 1.0; norm = 1.0; end
         s.x = 16'($rtoi(vx / norm * 16384.0));
         s.y = 16'($rtoi(vy / norm * 16384.0));
         s.z = 16'($rtoi(vz / norm * 16384.0));
      end else begin
         s.x = 16'($urandom); s.y = 16'($urandom); s.z = 16'($urandom);
      end
      s.r = 16'($urandom); s.g = 16'($urandom); s.b = 16'($urandom);
      return s;
   endfunction

   // runs of samples closed by a last item, now and then a stray last alone
   task automatic random_runs(int items);
      int run;
      while (items > 0) begin
         run = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 14);
         if (run > items) run = items;
         for (int i = 1; i <= run; i++) send_sample(random_sample(i == run));
         items -= run;
      end
   endtask

   // result check
   always @(posedge clock) begin
      coeff_type e;
      if (rsp_valid && !rsp_stall) begin
         if (pending_coeffs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected coefficient ch %0d idx %0d value %0d",
                        rsp_channel, rsp_coeff_index, rsp_coefficient);
         end else begin
            e = pending_coeffs.pop_front();
            if (e.channel !== rsp_channel || e.index !== rsp_coeff_index ||
                e.coeff !== rsp_coefficient || e.last !== rsp_last_coeff) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected ch %0d idx %0d %0d last %0b, ",
                            "got ch %0d idx %0d %0d last %0b"},
                           e.channel, e.index, e.coeff, e.last, rsp_channel,
                           rsp_coeff_index, rsp_coefficient, rsp_last_coeff);
            end
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[sh9_irradiance_projector_unit] ERROR");
         $finish;
      end
   end

   // receiver stalls
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0;
            rsp_stall = 1;
            repeat (HOLD_OFF) @(negedge clock);
            rsp_stall = 0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall = 1;
            repeat ($urandom_range(1, 4) - 1) @(negedge clock);
         end else begin
            rsp_stall = 0;
         end
      end
   end

   row_type directed [] = '{
      '{16384, 0, 0, 16'h0000, 16'h0000, 16'h0000, 1, 1},
      '{0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0},
      '{16384, 0, 0, 16'hFFFF, 16'h0000, 16'h0000, 0, 0},
      '{-16384, 0, 0, 16'h0000, 16'hFFFF, 16'h0000, 0, 0},
      '{0, 16384, 0, 16'h0000, 16'h0000, 16'hFFFF, 0, 0},
      '{0, -16384, 0, 16'h003F, 16'h0040, 16'h0041, 0, 0},
      '{0, 0, 16384, 16'h0001, 16'h8000, 16'h7FFF, 0, 0},
      '{0, 0, -16384, 16'hFFC0, 16'hFFBF, 16'h1234, 1, 0},
      '{-32768, -32768, -32768, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0},
      '{32767, 32767, 32767, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0},
      '{32767, -32768, 32767, 16'hAAAA, 16'h5555, 16'hFFFF, 1, 0},
      '{9459, 9459, 9459, 16'h4000, 16'hC000, 16'h2000, 0, 0},
      '{-9459, 9459, -9459, 16'hFFFF, 16'h0100, 16'hFF00, 1, 0},
      '{0, 0, 16384, 16'h0000, 16'h0000, 16'h0000, 1, 1},
      '{11585, -11585, 0, 16'h8001, 16'h7FFE, 16'h0F0F, 0, 0},
      '{0, 11585, 11585, 16'hF0F0, 16'h0000, 16'hFFFF, 1, 0}
   };

   initial begin
      build_gamma();
      for (int i = 0; i < 27; i++) coeff_sum[i] = 0;
      div_count = 16'd1024;
      repeat (8) @(negedge clock);
      reset = 0;
      foreach (directed[i]) send_sample(directed[i]);
      drain_and_settle();
      write_count(16'd1);
      random_runs(72);
      drain_and_settle();
      write_count(16'd65535);
      hold_request = 1;
      random_runs(72);
      drain_and_settle();
      write_count(16'd0);
      random_runs(72);
      drain_and_settle();
      write_count(16'($urandom_range(2, 65534)));
      random_runs(72);
      drain_and_settle();
      write_count(16'd1024);
      quiet = 1;
      random_runs(72);
      drain_and_settle();
      if (mismatches == 0) $display("[sh9_irradiance_projector_unit] OK");
      else $display("[sh9_irradiance_projector_unit] ERROR");
      $finish;
   end
endmodule
